### src/ltgq_pkg.sv
// Shared types, constants and helpers for the local tone gain quad block.
package ltgq_pkg;

   localparam int PIXEL_WIDTH            = 16;
   localparam int GAIN_W                 = 12;
   localparam int GAIN_FRAC_BITS_DEFAULT = 8;
   localparam int PIXEL_BITS_W           = 5;
   localparam int NUM_REGS               = 5;
   localparam int CSR_ADDR_W             = $clog2(NUM_REGS) + 2;
   localparam int CSR_DATA_W             = 32;

   typedef enum logic [2:0] {
      REG_ENABLE     = 3'd0,
      REG_PIXEL_BITS = 3'd1,
      REG_STRENGTH   = 3'd2,
      REG_GAIN_MIN   = 3'd3,
      REG_GAIN_MAX   = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic                    enable;
      logic [PIXEL_BITS_W-1:0] pixel_bits;
      logic [GAIN_W-1:0]       strength;
      logic [GAIN_W-1:0]       gain_min;
      logic [GAIN_W-1:0]       gain_max;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pix_top_left;
      logic [PIXEL_WIDTH-1:0] pix_top_right;
      logic [PIXEL_WIDTH-1:0] pix_bottom_left;
      logic [PIXEL_WIDTH-1:0] pix_bottom_right;
      logic [PIXEL_WIDTH-1:0] blurred_luma;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] out_top_left;
      logic [PIXEL_WIDTH-1:0] out_top_right;
      logic [PIXEL_WIDTH-1:0] out_bottom_left;
      logic [PIXEL_WIDTH-1:0] out_bottom_right;
      logic [GAIN_W-1:0]      applied_gain;
   } rsp_payload_type;

   // index 0 top left, 1 top right, 2 bottom left, 3 bottom right
   typedef logic [3:0][PIXEL_WIDTH-1:0] quad_type;

   typedef struct packed {
      quad_type               quad;
      logic [PIXEL_WIDTH-1:0] luma;
      logic [PIXEL_WIDTH-1:0] enh;
   } front_out_type;

   typedef struct packed {
      quad_type          quad;
      logic [GAIN_W-1:0] quot;
      logic              force_max;
   } div_out_type;

   function automatic logic [PIXEL_WIDTH-1:0] pix_max(input logic [PIXEL_BITS_W-1:0] bits);
      logic [PIXEL_BITS_W-1:0] b;
      logic [PIXEL_WIDTH:0]    full;
      b    = (bits > PIXEL_BITS_W'(PIXEL_WIDTH)) ? PIXEL_BITS_W'(PIXEL_WIDTH) : bits;
      full = ((PIXEL_WIDTH + 1)'(1) << b) - (PIXEL_WIDTH + 1)'(1);
      return full[PIXEL_WIDTH-1:0];
   endfunction

endpackage

### src/ltgq_ifs.sv
// Valid/ready stream interfaces for the quad input and the result output.
interface ltgq_req_if import ltgq_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ltgq_rsp_if import ltgq_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/ltgq_csr.sv
// APB-style configuration register file.
module ltgq_csr import ltgq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         REG_ENABLE: begin
            if (wr_en) cfg_in.enable = pwdata[0];
            prdata = CSR_DATA_W'(cfg_ff.enable);
         end
         REG_PIXEL_BITS: begin
            if (wr_en) cfg_in.pixel_bits = pwdata[PIXEL_BITS_W-1:0];
            prdata = CSR_DATA_W'(cfg_ff.pixel_bits);
         end
         REG_STRENGTH: begin
            if (wr_en) cfg_in.strength = pwdata[GAIN_W-1:0];
            prdata = CSR_DATA_W'(cfg_ff.strength);
         end
         REG_GAIN_MIN: begin
            if (wr_en) cfg_in.gain_min = pwdata[GAIN_W-1:0];
            prdata = CSR_DATA_W'(cfg_ff.gain_min);
         end
         REG_GAIN_MAX: begin
            if (wr_en) cfg_in.gain_max = pwdata[GAIN_W-1:0];
            prdata = CSR_DATA_W'(cfg_ff.gain_max);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b1;
         cfg_ff.pixel_bits <= PIXEL_BITS_W'(12);
         cfg_ff.strength   <= GAIN_W'(307);
         cfg_ff.gain_min   <= '0;
         cfg_ff.gain_max   <= GAIN_W'(512);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/ltgq_front.sv
// Front pipeline: quad luma, detail product, enhanced luma (four stages).
module ltgq_front import ltgq_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output front_out_type   out_data
);

   localparam int NS     = 4;
   localparam int PW     = PIXEL_WIDTH;
   localparam int PROD_W = PW + GAIN_W + 2;
   localparam int NUM_W  = PW + GAIN_W + GAIN_FRAC_BITS + 2;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] valid_prev;
   logic [NS:0]   ready;

   logic [PW-1:0] ymax;

   logic [PW+1:0]             sum_in;
   logic [PW-1:0]             mean_in;
   logic [PW-1:0]             s1_luma_in;
   quad_type                  s1_quad_ff;
   logic [PW-1:0]             s1_luma_ff;
   logic [PW-1:0]             s1_blur_ff;

   logic signed [PW:0]        diff_in;
   logic signed [PROD_W-1:0]  s2_prod_in;
   quad_type                  s2_quad_ff;
   logic [PW-1:0]             s2_luma_ff;
   logic [PW-1:0]             s2_blur_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff;

   logic signed [NUM_W-1:0]   s3_num_in;
   quad_type                  s3_quad_ff;
   logic [PW-1:0]             s3_luma_ff;
   logic signed [NUM_W-1:0]   s3_num_ff;

   logic                      positive;
   logic [NUM_W-1:0]          shifted;
   logic [PW-1:0]             s4_enh_in;
   quad_type                  s4_quad_ff;
   logic [PW-1:0]             s4_luma_ff;
   logic [PW-1:0]             s4_enh_ff;

   assign ymax = pix_max(cfg.pixel_bits);

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_comb begin
      ready[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_prev[0] = in_valid;
      for (int i = 1; i < NS; i++) begin
         valid_prev[i] = valid_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = ready[i] ? valid_prev[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      sum_in = (PW + 2)'(in_data.pix_top_left) + (PW + 2)'(in_data.pix_top_right)
             + (PW + 2)'(in_data.pix_bottom_left) + (PW + 2)'(in_data.pix_bottom_right)
             + (PW + 2)'(2);
      mean_in    = sum_in[PW+1:2];
      s1_luma_in = (mean_in > ymax) ? ymax : mean_in;
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_quad_ff <= {in_data.pix_bottom_right, in_data.pix_bottom_left,
                        in_data.pix_top_right, in_data.pix_top_left};
         s1_luma_ff <= s1_luma_in;
         s1_blur_ff <= in_data.blurred_luma;
      end
   end

   assign diff_in    = $signed({1'b0, s1_luma_ff}) - $signed({1'b0, s1_blur_ff});
   assign s2_prod_in = PROD_W'(diff_in) * PROD_W'($signed({1'b0, cfg.strength}));

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s2_quad_ff <= s1_quad_ff;
         s2_luma_ff <= s1_luma_ff;
         s2_blur_ff <= s1_blur_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   assign s3_num_in = NUM_W'(s2_prod_ff) + $signed(NUM_W'(s2_blur_ff) << GAIN_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s3_quad_ff <= s2_quad_ff;
         s3_luma_ff <= s2_luma_ff;
         s3_num_ff  <= s3_num_in;
      end
   end

   always_comb begin
      positive = !s3_num_ff[NUM_W-1] && (s3_num_ff != '0);
      shifted  = $unsigned(s3_num_ff) >> GAIN_FRAC_BITS;
      if (!positive) begin
         s4_enh_in = '0;
      end else if (shifted > NUM_W'(ymax)) begin
         s4_enh_in = ymax;
      end else begin
         s4_enh_in = shifted[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s4_quad_ff <= s3_quad_ff;
         s4_luma_ff <= s3_luma_ff;
         s4_enh_ff  <= s4_enh_in;
      end
   end

   assign out_data.quad = s4_quad_ff;
   assign out_data.luma = s4_luma_ff;
   assign out_data.enh  = s4_enh_ff;

endmodule

### src/ltgq_div.sv
// Pipelined restoring divider: gain quotient, one bit per stage, with saturation.
module ltgq_div import ltgq_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  front_out_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output div_out_type   out_data
);

   localparam int PW = PIXEL_WIDTH;
   localparam int NS = GAIN_W + 1;
   localparam int RW = PW + GAIN_W;
   localparam int XW = PW + GAIN_FRAC_BITS + GAIN_W;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] valid_prev;
   logic [NS:0]   ready;

   logic [RW-1:0]     rem_ff   [GAIN_W];
   logic [PW-1:0]     den_ff   [GAIN_W];
   logic [GAIN_W-1:0] quot_ff  [NS];
   logic              force_ff [NS];
   quad_type          quad_ff  [NS];

   logic [XW-1:0] num_x;
   logic [XW-1:0] den_x;
   logic          force_in;

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_comb begin
      ready[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_prev[0] = in_valid;
      for (int i = 1; i < NS; i++) begin
         valid_prev[i] = valid_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = ready[i] ? valid_prev[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // quotient wider than GAIN_W bits, or zero luma, clamps to gain_max
   assign num_x    = XW'(in_data.enh) << GAIN_FRAC_BITS;
   assign den_x    = XW'(in_data.luma) << GAIN_W;
   assign force_in = (in_data.luma == '0) || (num_x >= den_x);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         rem_ff[0]   <= num_x[RW-1:0];
         den_ff[0]   <= in_data.luma;
         quot_ff[0]  <= '0;
         force_ff[0] <= force_in;
         quad_ff[0]  <= in_data.quad;
      end
   end

   for (genvar j = 1; j < NS; j++) begin : g_bit
      localparam int K = GAIN_W - j;
      logic [RW:0]       trial;
      logic [GAIN_W-1:0] quot_next;

      assign trial = (RW + 1)'(rem_ff[j-1]) - ((RW + 1)'(den_ff[j-1]) << K);

      always_comb begin
         quot_next    = quot_ff[j-1];
         quot_next[K] = !trial[RW];
      end

      always_ff @(posedge clock) begin
         if (ready[j]) begin
            quot_ff[j]  <= quot_next;
            force_ff[j] <= force_ff[j-1];
            quad_ff[j]  <= quad_ff[j-1];
         end
      end

      if (j < GAIN_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (ready[j]) begin
               rem_ff[j] <= trial[RW] ? rem_ff[j-1] : trial[RW-1:0];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign out_data.quad      = quad_ff[NS-1];
   assign out_data.quot      = quot_ff[NS-1];
   assign out_data.force_max = force_ff[NS-1];

endmodule

### src/ltgq_scale.sv
// Back pipeline: gain clamp, pixel scaling, clip (or pass-through when disabled) and output register.
module ltgq_scale import ltgq_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  div_out_type     in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   localparam int NS = 3;
   localparam int PW = PIXEL_WIDTH;
   localparam int MW = PW + GAIN_W;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32'd1 << GAIN_FRAC_BITS);

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] valid_prev;
   logic [NS:0]   ready;

   logic [PW-1:0] ymax;

   logic [GAIN_W-1:0] raised;
   logic [GAIN_W-1:0] t1_gain_in;
   logic [GAIN_W-1:0] t1_gain_ff;
   quad_type          t1_quad_ff;

   logic [3:0][MW-1:0] t2_prod_in;
   logic [3:0][MW-1:0] t2_prod_ff;
   logic [GAIN_W-1:0]  t2_gain_ff;
   quad_type           t2_quad_ff;

   logic [MW-1:0]      shifted [4];
   quad_type           t3_pix_in;
   quad_type           t3_pix_ff;
   logic [GAIN_W-1:0]  t3_gain_in;
   logic [GAIN_W-1:0]  t3_gain_ff;

   assign ymax = pix_max(cfg.pixel_bits);

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_comb begin
      ready[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_prev[0] = in_valid;
      for (int i = 1; i < NS; i++) begin
         valid_prev[i] = valid_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = ready[i] ? valid_prev[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // raise to gain_min first, then lower to gain_max
   always_comb begin
      raised = (in_data.quot < cfg.gain_min) ? cfg.gain_min : in_data.quot;
      if (in_data.force_max || (raised > cfg.gain_max)) begin
         t1_gain_in = cfg.gain_max;
      end else begin
         t1_gain_in = raised;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         t1_gain_ff <= t1_gain_in;
         t1_quad_ff <= in_data.quad;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         t2_prod_in[k] = MW'(t1_quad_ff[k]) * MW'(t1_gain_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         t2_prod_ff <= t2_prod_in;
         t2_gain_ff <= t1_gain_ff;
         t2_quad_ff <= t1_quad_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         shifted[k] = t2_prod_ff[k] >> GAIN_FRAC_BITS;
         if (!cfg.enable) begin
            t3_pix_in[k] = t2_quad_ff[k];
         end else if (shifted[k] > MW'(ymax)) begin
            t3_pix_in[k] = ymax;
         end else begin
            t3_pix_in[k] = shifted[k][PW-1:0];
         end
      end
      t3_gain_in = cfg.enable ? t2_gain_ff : UNITY_GAIN;
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         t3_pix_ff  <= t3_pix_in;
         t3_gain_ff <= t3_gain_in;
      end
   end

   assign out_data.out_top_left     = t3_pix_ff[0];
   assign out_data.out_top_right    = t3_pix_ff[1];
   assign out_data.out_bottom_left  = t3_pix_ff[2];
   assign out_data.out_bottom_right = t3_pix_ff[3];
   assign out_data.applied_gain     = t3_gain_ff;

endmodule

### src/local_tone_gain_quad.sv
// Top level of the local tone gain quad block.
//
//  channel   direction  handshake             carries
//  req_if    in         valid/ready           four raw pixels + blurred luma
//  rsp_if    out        valid/ready           four scaled pixels + applied gain
//  csr       in/out     psel/penable/pready   enable, pixel_bits, strength, gain clamps
//
// One item enters per clock while the pipeline is not stalled; its result comes out through
// 20 register stages: 4 luma/detail front, 13 gain divider (load, then a bit per stage), 3 scaler.
// Reset clears every stage valid bit and loads the register reset values.
// Each stage holds while the one after it is full and stalled; empty stages still
// take items, so input is accepted while a result waits at the output until all stages fill.
module local_tone_gain_quad import ltgq_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   ltgq_req_if.sink              req_if,
   ltgq_rsp_if.source            rsp_if
);

   cfg_type       cfg;
   logic          front_valid;
   logic          front_ready;
   front_out_type front_data;
   logic          div_valid;
   logic          div_ready;
   div_out_type   div_data;

   ltgq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ltgq_front #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_if.payload),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   ltgq_div #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   ltgq_scale #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_if.payload)
   );

endmodule

### src/ltgq_checker.sv
// Port-level checker for the local tone gain quad block, bound to the top level.
module ltgq_checker import ltgq_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   a_no_result_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready)
      else $error("input not ready right after reset");

   a_empty_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage is empty");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result dropped or changed");

endmodule

bind local_tone_gain_quad ltgq_checker u_ltgq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

### verif/ltgq_tone_checker.sv
// Checker that predicts the gain-adjusted quad for every accepted item and compares results.
module ltgq_tone_checker import ltgq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   ltgq_req_if                   req_if,
   ltgq_rsp_if                   rsp_if,
   output int                    quads_in_flight,
   output int                    mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = GAIN_FRAC_BITS_DEFAULT;

   cfg_type         tone_cfg;
   rsp_payload_type expected_quads [$];
   int              result_index;

   initial begin
      quads_in_flight = 0;
      mismatch_count  = 0;
      result_index    = 0;
   end

   function automatic rsp_payload_type predict_tone(input req_payload_type q);
      rsp_payload_type r;
      longint unsigned px [4];
      longint unsigned adj [4];
      longint unsigned ceiling, luma, enh, gain, blur;
      longint          detail;
      int unsigned     depth;
      px[0] = q.pix_top_left;
      px[1] = q.pix_top_right;
      px[2] = q.pix_bottom_left;
      px[3] = q.pix_bottom_right;
      blur  = q.blurred_luma;
      depth = (tone_cfg.pixel_bits > PIXEL_WIDTH) ? PIXEL_WIDTH : tone_cfg.pixel_bits;
      ceiling = (64'd1 << depth) - 64'd1;
      if (!tone_cfg.enable) begin
         for (int k = 0; k < 4; k++) adj[k] = px[k];
         gain = 64'd1 << FRAC;
      end else begin
         luma = (px[0] + px[1] + px[2] + px[3] + 64'd2) >> 2;
         if (luma > ceiling) luma = ceiling;
         detail = (longint'(luma) - longint'(blur)) * longint'(tone_cfg.strength)
                + longint'(blur << FRAC);
         if (detail <= 0) begin
            enh = 0;
         end else begin
            enh = detail;
            enh = enh >> FRAC;
            if (enh > ceiling) enh = ceiling;
         end
         if (luma == 0) begin
            gain = tone_cfg.gain_max;
         end else begin
            gain = (enh << FRAC) / luma;
            if (gain < tone_cfg.gain_min) gain = tone_cfg.gain_min;
            if (gain > tone_cfg.gain_max) gain = tone_cfg.gain_max;
         end
         for (int k = 0; k < 4; k++) begin
            adj[k] = (px[k] * gain) >> FRAC;
            if (adj[k] > ceiling) adj[k] = ceiling;
         end
      end
      r.out_top_left     = PIXEL_WIDTH'(adj[0]);
      r.out_top_right    = PIXEL_WIDTH'(adj[1]);
      r.out_bottom_left  = PIXEL_WIDTH'(adj[2]);
      r.out_bottom_right = PIXEL_WIDTH'(adj[3]);
      r.applied_gain     = GAIN_W'(gain);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   result_index, name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (reset) begin
         tone_cfg.enable     = 1'b1;
         tone_cfg.pixel_bits = 5'd12;
         tone_cfg.strength   = 12'd307;
         tone_cfg.gain_min   = 12'd0;
         tone_cfg.gain_max   = 12'd512;
         expected_quads.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_ENABLE:     tone_cfg.enable     = pwdata[0];
               REG_PIXEL_BITS: tone_cfg.pixel_bits = pwdata[PIXEL_BITS_W-1:0];
               REG_STRENGTH:   tone_cfg.strength   = pwdata[GAIN_W-1:0];
               REG_GAIN_MIN:   tone_cfg.gain_min   = pwdata[GAIN_W-1:0];
               REG_GAIN_MAX:   tone_cfg.gain_max   = pwdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_quads.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                         result_index));
            end else begin
               want = expected_quads.pop_front();
               check_field("out_top_left", got.out_top_left, want.out_top_left);
               check_field("out_top_right", got.out_top_right, want.out_top_right);
               check_field("out_bottom_left", got.out_bottom_left, want.out_bottom_left);
               check_field("out_bottom_right", got.out_bottom_right, want.out_bottom_right);
               check_field("applied_gain", got.applied_gain, want.applied_gain);
            end
            result_index++;
         end
         if (req_if.valid && req_if.ready) expected_quads.push_back(predict_tone(req_if.payload));
      end
      quads_in_flight <= expected_quads.size();
   end

endmodule

### verif/tb.sv
// Testbench top for the local tone gain quad block: stimulus, register setup and verdict.
module tb import ltgq_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT     = 500000;
   localparam int         RANDOM_PHASES   = 12;
   localparam int         QUADS_PER_PHASE = 152;
   localparam logic [2:0] REG_UNMAPPED    = 3'd7;

   typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_BURSTY} drain_mode_type;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  drain_ready = 1'b0;
   drain_mode_type        drain_mode  = DRAIN_FREE;
   int                    drain_tick  = 0;
   int                    cycle_count = 0;
   int                    burst_left  = 0;
   int                    pix_ceiling = 4095;
   int                    quads_in_flight;
   int                    mismatch_count;

   ltgq_req_if req_if ();
   ltgq_rsp_if rsp_if ();

   assign rsp_if.ready = drain_ready;

   local_tone_gain_quad i_dut (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .req_if  (req_if),
      .rsp_if  (rsp_if)
   );

   ltgq_tone_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .quads_in_flight (quads_in_flight),
      .mismatch_count  (mismatch_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (drain_tick % 256 == 0) drain_mode = drain_mode_type'($urandom_range(0, 3));
      case (drain_mode)
         DRAIN_FREE:   drain_ready <= 1'b1;
         DRAIN_COIN:   drain_ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE: drain_ready <= (drain_tick % 4 == 0);
         default:      drain_ready <= (drain_tick % 16 >= 12);
      endcase
      drain_tick++;
   end

   task automatic csr_write(input logic [2:0] index, input int unsigned value, input int width);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      if ($urandom_range(0, 1)) data = data | ($urandom << width);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_all(input int en, input int bits, input int strength,
                              input int gmin, input int gmax);
      csr_write(REG_ENABLE, en, 1);
      csr_write(REG_PIXEL_BITS, bits, PIXEL_BITS_W);
      csr_write(REG_STRENGTH, strength, GAIN_W);
      csr_write(REG_GAIN_MIN, gmin, GAIN_W);
      csr_write(REG_GAIN_MAX, gmax, GAIN_W);
      pix_ceiling = (1 << ((bits > PIXEL_WIDTH) ? PIXEL_WIDTH : bits)) - 1;
   endtask

   task automatic send_quad(input req_payload_type item);
      int gap;
      int pick;
      if (burst_left == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)      gap = 0;
         else if (pick < 8) gap = $urandom_range(1, 4);
         else if (pick < 9) gap = $urandom_range(5, 12);
         else               gap = $urandom_range(13, 30);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (quads_in_flight != 0) @(posedge clock);
   endtask

   function automatic req_payload_type quad(input logic [15:0] tl, input logic [15:0] tr,
                                            input logic [15:0] bl, input logic [15:0] br,
                                            input logic [15:0] blur);
      return '{tl, tr, bl, br, blur};
   endfunction

   function automatic logic [PIXEL_WIDTH-1:0] near(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return PIXEL_WIDTH'(v);
   endfunction

   function automatic logic [PIXEL_WIDTH-1:0] corner_pixel();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 16'd1;
         2:       return PIXEL_WIDTH'(pix_ceiling);
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic req_payload_type random_quad();
      req_payload_type q;
      int pick, base, spread;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         base   = $urandom_range(0, pix_ceiling);
         spread = 1 + pix_ceiling / 8;
         q = quad(near(base, spread), near(base, spread), near(base, spread),
                  near(base, spread), near(base, 2 * spread));
      end else if (pick < 17) begin
         q = quad(PIXEL_WIDTH'($urandom), PIXEL_WIDTH'($urandom), PIXEL_WIDTH'($urandom),
                  PIXEL_WIDTH'($urandom), PIXEL_WIDTH'($urandom));
      end else begin
         q = quad(corner_pixel(), corner_pixel(), corner_pixel(), corner_pixel(),
                  corner_pixel());
      end
      return q;
   endfunction

   initial begin
      int en, bits, strength, gmin, gmax;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values
      send_quad(quad(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_quad(quad(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
      send_quad(quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
      send_quad(quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_quad(quad(16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF));
      send_quad(quad(16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
      send_quad(quad(16'd1, 16'd0, 16'd0, 16'd0, 16'd5));
      send_quad(quad(16'd100, 16'd100, 16'd100, 16'd100, 16'd4000));
      send_quad(quad(16'd2000, 16'd2100, 16'd1900, 16'd2050, 16'd1000));
      send_quad(quad(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555));
      send_quad(quad(16'd3000, 16'd10, 16'd4095, 16'd0, 16'd8000));

      // crossed gain clamps
      drain_all();
      program_all(1, 16, 4095, 3000, 200);
      send_quad(quad(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
      send_quad(quad(16'd50000, 16'd60000, 16'd65535, 16'd40000, 16'd100));
      send_quad(quad(16'd0, 16'd0, 16'd0, 16'd0, 16'd300));

      // pixel depth zero, out of range, then a narrow depth
      drain_all();
      program_all(1, 0, 307, 0, 512);
      send_quad(quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
      send_quad(quad(16'd5, 16'd6, 16'd7, 16'd8, 16'd3));
      drain_all();
      program_all(1, 31, 600, 100, 2000);
      send_quad(quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_quad(quad(16'd32768, 16'd12, 16'd40000, 16'd7, 16'd20000));
      drain_all();
      program_all(1, 7, 512, 0, 4095);
      send_quad(quad(16'd200, 16'd100, 16'd50, 16'd127, 16'd64));

      // pass-through, then a write outside the register map
      drain_all();
      program_all(0, 12, 307, 0, 512);
      send_quad(quad(16'hFFFF, 16'h0000, 16'd1234, 16'd8000, 16'd77));
      send_quad(quad(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      drain_all();
      csr_write(REG_UNMAPPED, $urandom, 31);
      send_quad(quad(16'd4000, 16'd3000, 16'd2000, 16'd1000, 16'd2500));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_all();
         en = 1;
         case (phase)
            0: begin
               bits = 16; strength = 4095; gmin = 4095; gmax = 4095;
            end
            1: begin
               bits = 8; strength = 0; gmin = 0; gmax = 0;
            end
            2: begin
               bits = 16; strength = 256; gmin = 0; gmax = 4095;
            end
            default: begin
               bits = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(8, 16);
               strength = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(128, 512);
               gmin = $urandom_range(0, 640);
               gmax = $urandom_range(128, 4095);
               if ($urandom_range(0, 9) == 0) gmin = $urandom_range(gmax, 4095);
               en = ($urandom_range(0, 7) != 0);
            end
         endcase
         if (phase == 3) en = 0;
         program_all(en, bits, strength, gmin, gmax);
         repeat (QUADS_PER_PHASE) send_quad(random_quad());
      end

      drain_all();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### local_tone_gain_quad.f
src/ltgq_pkg.sv
src/ltgq_ifs.sv
src/ltgq_csr.sv
src/ltgq_front.sv
src/ltgq_div.sv
src/ltgq_scale.sv
src/local_tone_gain_quad.sv
src/ltgq_checker.sv
verif/ltgq_tone_checker.sv
verif/tb.sv
